FILE: design/bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch dispense sequencer package
// Field widths, phase codes, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package bds_pkg;

  // Phase codes as seen on the result channel
  localparam logic [2:0] PHASE_IDLE    = 3'd0;
  localparam logic [2:0] PHASE_MEASURE = 3'd1;
  localparam logic [2:0] PHASE_SERVO   = 3'd2;
  localparam logic [2:0] PHASE_THROW   = 3'd3;
  localparam logic [2:0] PHASE_AFTER   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] REG_SERVO_MIN   = 3'd1;
  localparam logic [2:0] REG_SERVO_OPEN  = 3'd2;
  localparam logic [2:0] REG_MOTOR_SPAN  = 3'd3;
  localparam logic [2:0] REG_TOTAL_TMO   = 3'd4;
  localparam logic [2:0] REG_THROW_TIME  = 3'd5;

  // Opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Fixed constants
  localparam logic [31:0] SETTLE_SPACING_MS = 32'd1000;
  localparam int unsigned SHARE_MARGIN      = 3;
  localparam int signed   KD_SWITCH_ERROR   = 15;
  localparam int unsigned KD_HIGH_TWICE     = 20;

  // Shared divider geometry
  localparam int unsigned DIV_W   = 21;
  localparam int unsigned DIVR_W  = 4;
  localparam logic [3:0]  DIV_BY_THREE = 4'd3;

  // Reset values of the configuration registers
  localparam logic [3:0]  RST_LEVEL_COUNT = 4'd3;
  localparam logic [15:0] RST_SERVO_MIN   = 16'd500;
  localparam logic [15:0] RST_SERVO_OPEN  = 16'd2500;
  localparam logic [15:0] RST_MOTOR_SPAN  = 16'd999;
  localparam logic [31:0] RST_TOTAL_TMO   = 32'd300000;
  localparam logic [31:0] RST_THROW_TIME  = 32'd20000;

endpackage

FILE: design/batch_dispense_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch dispense sequencer
// Splits a target mass into levels; settles the load cells, drives the servo
// from a PID, runs the thrower motor and settles again for every level.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid_i / in_stall_o | opcode, now_ms, cells, target
//  out      | output    | out_valid_o/ out_stall_i| phase, level, servo, motor, abt
//  cfg      | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// An item that needs no division goes from evaluation to the output state,
// through the settle test when one is made; otherwise it also passes the
// 21-step restoring divider (one quotient bit a cycle), shared by the level
// share, the motor duty and the settled mean.
// The input stalls until the result is loaded into the output register; a
// stalled output holds the sequencer in its final state only.
// Reset clears all state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module batch_dispense_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic signed [15:0] cell_a_i,
  input  logic signed [15:0] cell_b_i,
  input  logic signed [15:0] cell_c_i,
  input  logic [14:0] target_mass_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  phase_o,
  output logic [4:0]  current_level_o,
  output logic        servo_enable_o,
  output logic [15:0] servo_count_o,
  output logic        motor_enable_o,
  output logic [15:0] motor_duty_o,
  output logic        aborted_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_SETTLE, ST_DIV, ST_FIN, ST_PID, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration
  logic [3:0]  lvl_cnt_q;
  logic [15:0] srv_min_q, srv_open_q, mot_span_q;
  logic [31:0] tot_tmo_q, throw_time_q;

  // Latched item
  logic               op_q;
  logic [31:0]        now_q;
  logic signed [17:0] sum_q;
  logic [14:0]        target_q;

  // Sequence state
  logic [2:0]         phase_q;
  logic [4:0]         level_q;
  logic signed [17:0] samp_q [3];
  logic [1:0]         sidx_q;
  logic [31:0]        sstamp_q, start_q, throw_q;
  logic signed [17:0] tare_q;
  logic signed [31:0] integ_q;
  logic signed [16:0] prev_q;

  // Shared divider
  logic [bds_pkg::DIV_W-1:0]  dvd_q;
  logic [bds_pkg::DIVR_W-1:0] rem_q, divisor_q;
  logic [4:0]                 dcnt_q;
  logic                       neg_q;

  // PID working terms
  logic signed [16:0] e_q;
  logic signed [22:0] kdd_q;

  // Result under construction and output register
  logic        srv_en_q, mot_en_q, abt_q;
  logic [15:0] srv_q;
  logic [15:0] mot_duty_q;
  logic        ov_q;
  logic [2:0]  o_phase_q;
  logic [4:0]  o_level_q;
  logic        o_srv_en_q, o_mot_en_q, o_abt_q;
  logic [15:0] o_srv_q, o_mot_q;

  // Sum the load cells
  logic signed [17:0] cell_sum;
  assign cell_sum = 18'(cell_a_i) + 18'(cell_b_i) + 18'(cell_c_i);

  // Abort and sample timing
  logic abort_c, take_c;
  assign abort_c = (level_q > {1'b0, lvl_cnt_q}) || ((now_q - start_q) >= tot_tmo_q);
  assign take_c  = (now_q - sstamp_q) >= bds_pkg::SETTLE_SPACING_MS;

  // Settle test over the stored samples
  logic signed [18:0] df01, df12;
  logic [18:0]        ad01, ad12;
  logic [19:0]        dsum;
  logic signed [19:0] s3;
  logic [19:0]        s3_mag;
  assign df01   = 19'(samp_q[0]) - 19'(samp_q[1]);
  assign df12   = 19'(samp_q[1]) - 19'(samp_q[2]);
  assign ad01   = df01[18] ? 19'(-df01) : 19'(df01);
  assign ad12   = df12[18] ? 19'(-df12) : 19'(df12);
  assign dsum   = 20'(ad01) + 20'(ad12);
  assign s3     = 20'(samp_q[0]) + 20'(samp_q[1]) + 20'(samp_q[2]);
  assign s3_mag = s3[19] ? 20'(-s3) : 20'(s3);

  // One divider step
  logic [4:0]                 rem_sh;
  logic                       qbit;
  logic [bds_pkg::DIVR_W-1:0] rem_nx;
  assign rem_sh = {rem_q, dvd_q[bds_pkg::DIV_W-1]};
  assign qbit   = rem_sh >= {1'b0, divisor_q};
  assign rem_nx = qbit ? 4'(rem_sh - {1'b0, divisor_q}) : rem_sh[3:0];

  // Products into the divider
  logic [19:0] share_prod;
  logic [20:0] motor_prod;
  assign share_prod = 20'(target_q) * 20'(level_q);
  assign motor_prod = 21'(mot_span_q) * 21'(level_q);

  // Settled mass, share, error and integral update
  logic signed [17:0] settled;
  logic signed [21:0] share, mass;
  logic signed [16:0] e_c;
  logic signed [17:0] d_c;
  logic signed [33:0] i_ext;
  logic signed [31:0] integ_nx;
  logic signed [22:0] kdd_c;
  always_comb begin
    settled = neg_q ? 18'(-$signed({1'b0, dvd_q})) : 18'(dvd_q);
    share   = $signed({1'b0, dvd_q}) - 22'(bds_pkg::SHARE_MARGIN);
    mass    = 22'(tare_q) - 22'(sum_q);
    e_c     = 17'($signed(share[15:0])) - 17'($signed(mass[15:0]));
    d_c     = 18'(e_c) - 18'(prev_q);
    kdd_c   = (32'(e_c) <= bds_pkg::KD_SWITCH_ERROR)
              ? 23'(d_c) * 23'(bds_pkg::KD_HIGH_TWICE) : 23'(d_c);
    if (e_c == prev_q) i_ext = 34'(integ_q) + 34'(e_c);
    else               i_ext = 34'(integ_q) - 34'(e_c);
    if (i_ext > 34'sh0_7FFF_FFFF)       integ_nx = 32'sh7FFF_FFFF;
    else if (i_ext < -34'sh0_8000_0000) integ_nx = 32'sh8000_0000;
    else                                integ_nx = i_ext[31:0];
    if (e_c != prev_q && integ_q <= 0) integ_nx = '0;
  end

  // PID sum, halve toward zero, clamp
  logic signed [34:0] pid_sum, pid_half;
  logic signed [35:0] srv_v;
  logic [15:0]        srv_c;
  always_comb begin
    pid_sum  = 35'(e_q) * 35'sd2 + 35'(integ_q) + 35'(kdd_q);
    pid_half = pid_sum[34] ? ((pid_sum + 35'sd1) >>> 1) : (pid_sum >>> 1);
    srv_v    = $signed({20'd0, srv_min_q}) + 36'(pid_half);
    if (srv_v > $signed({20'd0, srv_open_q}))     srv_c = srv_open_q;
    else if (srv_v < $signed({20'd0, srv_min_q})) srv_c = srv_min_q;
    else                                          srv_c = srv_v[15:0];
  end

  assign in_stall_o = state_q != ST_IDLE;

  // Output register load: result ready and the register free
  logic load_c;
  assign load_c = (state_q == ST_OUT) && (!ov_q || !out_stall_i);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_cnt_q    <= bds_pkg::RST_LEVEL_COUNT;
      srv_min_q    <= bds_pkg::RST_SERVO_MIN;
      srv_open_q   <= bds_pkg::RST_SERVO_OPEN;
      mot_span_q   <= bds_pkg::RST_MOTOR_SPAN;
      tot_tmo_q    <= bds_pkg::RST_TOTAL_TMO;
      throw_time_q <= bds_pkg::RST_THROW_TIME;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bds_pkg::REG_LEVEL_COUNT: lvl_cnt_q    <= cfg_data_i[3:0];
        bds_pkg::REG_SERVO_MIN:   srv_min_q    <= cfg_data_i[15:0];
        bds_pkg::REG_SERVO_OPEN:  srv_open_q   <= cfg_data_i[15:0];
        bds_pkg::REG_MOTOR_SPAN:  mot_span_q   <= cfg_data_i[15:0];
        bds_pkg::REG_TOTAL_TMO:   tot_tmo_q    <= cfg_data_i;
        bds_pkg::REG_THROW_TIME:  throw_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= bds_pkg::PHASE_IDLE;
      level_q   <= '0;
      samp_q[0] <= '0;
      samp_q[1] <= '0;
      samp_q[2] <= '0;
      sidx_q    <= '0;
      sstamp_q  <= '0;
      start_q   <= '0;
      throw_q   <= '0;
      tare_q    <= '0;
      integ_q   <= '0;
      prev_q    <= '0;
      ov_q      <= 1'b0;
      op_q      <= 1'b0;
      now_q     <= '0;
      sum_q     <= '0;
      target_q  <= '0;
      dvd_q     <= '0;
      rem_q     <= '0;
      divisor_q <= '0;
      dcnt_q    <= '0;
      neg_q     <= 1'b0;
      e_q       <= '0;
      kdd_q     <= '0;
      srv_en_q  <= 1'b0;
      mot_en_q  <= 1'b0;
      abt_q     <= 1'b0;
      srv_q     <= '0;
      mot_duty_q <= '0;
      o_phase_q <= '0;
      o_level_q <= '0;
      o_srv_en_q <= 1'b0;
      o_mot_en_q <= 1'b0;
      o_abt_q   <= 1'b0;
      o_srv_q   <= '0;
      o_mot_q   <= '0;
    end else begin
      // Set valid on a load, drop it once transferred
      if (load_c) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q     <= opcode_i;
            now_q    <= now_ms_i;
            sum_q    <= cell_sum;
            target_q <= target_mass_i;
            state_q  <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          srv_en_q   <= 1'b0;
          mot_en_q   <= 1'b0;
          abt_q      <= 1'b0;
          mot_duty_q <= '0;
          dcnt_q     <= '0;
          rem_q      <= '0;
          if (op_q == bds_pkg::OP_START) begin
            phase_q <= bds_pkg::PHASE_MEASURE;
            level_q <= 5'd1;
            integ_q <= '0;
            prev_q  <= '0;
            start_q <= now_q;
            state_q <= ST_OUT;
          end else if (phase_q == bds_pkg::PHASE_IDLE || phase_q > bds_pkg::PHASE_AFTER) begin
            state_q <= ST_OUT;
          end else if (abort_c) begin
            phase_q <= bds_pkg::PHASE_IDLE;
            abt_q   <= 1'b1;
            state_q <= ST_OUT;
          end else begin
            case (phase_q)
              bds_pkg::PHASE_SERVO: begin
                dvd_q     <= 21'(share_prod);
                divisor_q <= lvl_cnt_q;
                state_q   <= ST_DIV;
              end
              bds_pkg::PHASE_THROW: begin
                dvd_q     <= motor_prod;
                divisor_q <= lvl_cnt_q;
                state_q   <= ST_DIV;
              end
              default: begin
                // Take a settle sample when spacing has elapsed
                if (take_c) begin
                  samp_q[sidx_q] <= sum_q;
                  sidx_q         <= (sidx_q == 2'd2) ? 2'd0 : sidx_q + 2'd1;
                  sstamp_q       <= now_q;
                end
                state_q <= ST_SETTLE;
              end
            endcase
          end
        end

        ST_SETTLE: begin
          if (sidx_q != 2'd0 || dsum > 20'd3) begin
            state_q <= ST_OUT;
          end else begin
            dvd_q     <= 21'(s3_mag);
            neg_q     <= s3[19];
            divisor_q <= bds_pkg::DIV_BY_THREE;
            state_q   <= ST_DIV;
          end
        end

        ST_DIV: begin
          // One quotient bit a cycle
          dvd_q  <= {dvd_q[bds_pkg::DIV_W-2:0], qbit};
          rem_q  <= rem_nx;
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'(bds_pkg::DIV_W - 1)) state_q <= ST_FIN;
        end

        ST_FIN: begin
          case (phase_q)
            bds_pkg::PHASE_SERVO: begin
              integ_q  <= integ_nx;
              prev_q   <= e_c;
              e_q      <= e_c;
              kdd_q    <= kdd_c;
              srv_en_q <= 1'b1;
              if (mass > share) begin
                phase_q <= bds_pkg::PHASE_THROW;
                throw_q <= now_q;
              end
              state_q <= ST_PID;
            end
            bds_pkg::PHASE_THROW: begin
              mot_en_q   <= 1'b1;
              mot_duty_q <= dvd_q[15:0];
              if ((now_q - throw_q) > throw_time_q) begin
                phase_q <= bds_pkg::PHASE_AFTER;
                integ_q <= '0;
                prev_q  <= '0;
              end
              state_q <= ST_OUT;
            end
            bds_pkg::PHASE_MEASURE: begin
              if (level_q == 5'd1) tare_q <= settled;
              phase_q <= bds_pkg::PHASE_SERVO;
              state_q <= ST_OUT;
            end
            default: begin
              // Settled after the throw: next level, sample at once
              phase_q  <= bds_pkg::PHASE_MEASURE;
              sstamp_q <= sstamp_q - bds_pkg::SETTLE_SPACING_MS;
              level_q  <= level_q + 5'd1;
              state_q  <= ST_OUT;
            end
          endcase
        end

        ST_PID: begin
          srv_q   <= srv_c;
          state_q <= ST_OUT;
        end

        ST_OUT: begin
          // Load the output register once it is free
          if (load_c) begin
            o_phase_q  <= phase_q;
            o_level_q  <= level_q;
            o_srv_en_q <= srv_en_q;
            o_mot_en_q <= mot_en_q;
            o_abt_q    <= abt_q;
            o_mot_q    <= mot_duty_q;
            o_srv_q    <= srv_en_q ? srv_q : '0;
            state_q    <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign phase_o         = o_phase_q;
  assign current_level_o = o_level_q;
  assign servo_enable_o  = o_srv_en_q;
  assign servo_count_o   = o_srv_q;
  assign motor_enable_o  = o_mot_en_q;
  assign motor_duty_o    = o_mot_q;
  assign aborted_o       = o_abt_q;

endmodule
